// ===== src/jitl_pkg.sv =====
`timescale 1ns / 1ps

package jitl_pkg;

	// joint count and fixed-point formats
	localparam int JOINTS    = 7;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 64;
	localparam int LIMIT_W   = 31;
	localparam int SMOOTH_W  = 17;

	typedef logic signed [31:0] q16_t;
	typedef logic [2:0]         joint_t;
	typedef logic [GAIN_W-1:0]  gain_t;

	// velocity filter weights, Q1.16
	localparam logic [SMOOTH_W-1:0] ALPHA_Q16 = 17'd64881;
	localparam logic [SMOOTH_W-1:0] ONE_Q16   = 17'd65536;
	localparam logic [SMOOTH_W-1:0] BETA_Q16  = ONE_Q16 - ALPHA_Q16;

	// register indexes
	typedef enum logic [2:0] {
		REG_STIFF_LO = 3'd0,
		REG_STIFF_HI = 3'd1,
		REG_DAMP_LO  = 3'd2,
		REG_DAMP_HI  = 3'd3,
		REG_COR_SCALE = 3'd4,
		REG_SMOOTH   = 3'd5,
		REG_LIMIT    = 3'd6
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIFF,
		S_FIN
	} state_t;

	// multiply steps of the shared unit
	typedef enum logic [2:0] {
		ST_FV_HIST = 3'd0,
		ST_FV_MEAS = 3'd1,
		ST_FT_HIST = 3'd2,
		ST_FT_TGT  = 3'd3,
		ST_COR     = 3'd4,
		ST_STIFF   = 3'd5,
		ST_DAMP    = 3'd6,
		ST_LAST    = 3'd7
	} step_t;

endpackage

// ===== src/jitl_if.sv =====
`timescale 1ns / 1ps

// joint sample channel
interface jitl_sample_if import jitl_pkg::*; ();
	logic   valid;
	logic   ready;
	joint_t joint_index;
	q16_t   measured_position;
	q16_t   measured_velocity;
	q16_t   coriolis_torque;
	q16_t   last_desired_torque;
	q16_t   target_position;

	modport source (
		output valid, joint_index, measured_position, measured_velocity,
		       coriolis_torque, last_desired_torque, target_position,
		input  ready
	);
	modport sink (
		input  valid, joint_index, measured_position, measured_velocity,
		       coriolis_torque, last_desired_torque, target_position,
		output ready
	);
endinterface

// torque command channel
interface jitl_command_if import jitl_pkg::*; ();
	logic   valid;
	logic   ready;
	joint_t joint_number;
	q16_t   torque_command;
	logic   rate_limited;

	modport source (
		output valid, joint_number, torque_command, rate_limited,
		input  ready
	);
	modport sink (
		input  valid, joint_number, torque_command, rate_limited,
		output ready
	);
endinterface

// ===== src/joint_impedance_torque_law.sv =====
`timescale 1ns / 1ps

// Joint impedance torque law with a per-step torque rate limit. Each sample request
// carries one joint's measurements; the block keeps a filtered velocity and a filtered
// target per joint, forms scaled Coriolis plus stiffness times position error minus
// damping times filtered velocity, saturates it, then clamps the change from the last
// desired torque to the step limit and flags the clamp. All seven products go through
// one shared 34 x 18 bit multiplier, one product per cycle; a sample passes through
// acceptance, the multiply/accumulate steps, a difference step and a clamp step before
// the next acceptance. A joint index beyond the joint count skips the multiplier and
// goes from acceptance straight to the clamp step. The command sits in an output
// register, so a new sample is accepted while the previous command waits to be taken;
// the clamp step only stretches while an earlier command still waits in that register.
module joint_impedance_torque_law import jitl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	jitl_sample_if.sink              sample,
	jitl_command_if.source           command
);

	// configuration registers
	logic [63:0]         stiff_lo_q;
	logic [47:0]         stiff_hi_q;
	logic [63:0]         damp_lo_q;
	logic [47:0]         damp_hi_q;
	logic [15:0]         cor_scale_q;
	logic [SMOOTH_W-1:0] smooth_q;
	logic [LIMIT_W-1:0]  limit_q;

	// per-joint filter state
	q16_t fv_q [JOINTS];
	q16_t ft_q [JOINTS];

	// latched sample
	joint_t j_q;
	q16_t   pos_q;
	q16_t   vel_q;
	q16_t   cor_q;
	q16_t   last_q;
	q16_t   tgt_q;
	logic   bypass_q;

	// sequencer and datapath
	state_t             state_q, state_d;
	logic [2:0]         step_q;
	logic signed [33:0] op_a;
	logic signed [17:0] op_b;
	logic signed [51:0] prod_q;
	logic signed [51:0] acc_q;
	q16_t               fv_new_q;
	q16_t               ft_new_q;
	logic signed [47:0] tau_q;
	logic signed [32:0] diff_q;

	logic               in_range;
	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               busy_ready;
	logic [SMOOTH_W-1:0] w_sat;
	gain_t              k_gain;
	gain_t              d_gain;
	q16_t               fv_old;
	q16_t               ft_old;
	logic signed [51:0] sum_round16;
	logic signed [51:0] r14;
	logic signed [51:0] r4;
	q16_t               tau_sat;
	logic signed [32:0] lim33;
	logic signed [32:0] diff_clamped;
	logic               clamp_flag;
	logic signed [33:0] cmd_wide;
	q16_t               cmd_sat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_lo_q  <= '0;
			stiff_hi_q  <= '0;
			damp_lo_q   <= '0;
			damp_hi_q   <= '0;
			cor_scale_q <= 16'd16384;
			smooth_q    <= 17'd655;
			limit_q     <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STIFF_LO:  stiff_lo_q  <= cfg_data;
				REG_STIFF_HI:  stiff_hi_q  <= cfg_data[47:0];
				REG_DAMP_LO:   damp_lo_q   <= cfg_data;
				REG_DAMP_HI:   damp_hi_q   <= cfg_data[47:0];
				REG_COR_SCALE: cor_scale_q <= cfg_data[15:0];
				REG_SMOOTH:    smooth_q    <= cfg_data[SMOOTH_W-1:0];
				REG_LIMIT:     limit_q     <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake terms
	assign in_range = {1'b0, sample.joint_index} < 4'(JOINTS);
	assign accept   = sample.valid && busy_ready;
	assign out_free = !command.valid || command.ready;
	assign sample.ready = busy_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (sample.valid) state_d = in_range ? S_MUL : S_FIN;
			S_MUL:  if (step_q == ST_LAST) state_d = S_DIFF;
			S_DIFF: state_d = S_FIN;
			S_FIN:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy_ready = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE:  busy_ready = 1'b1;
			S_FIN:   out_load   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				step_q <= '0;
			else if (state_q == S_MUL)
				step_q <= step_q + 3'd1;
		end
	end

	// sample latch
	always_ff @(posedge clk) begin
		if (accept) begin
			j_q      <= sample.joint_index;
			pos_q    <= sample.measured_position;
			vel_q    <= sample.measured_velocity;
			cor_q    <= sample.coriolis_torque;
			last_q   <= sample.last_desired_torque;
			tgt_q    <= sample.target_position;
			bypass_q <= !in_range;
		end
	end

	// gain lookup, joints past the gain registers get zero
	always_comb begin
		case (j_q)
			3'd0: begin k_gain = stiff_lo_q[15:0];  d_gain = damp_lo_q[15:0];  end
			3'd1: begin k_gain = stiff_lo_q[31:16]; d_gain = damp_lo_q[31:16]; end
			3'd2: begin k_gain = stiff_lo_q[47:32]; d_gain = damp_lo_q[47:32]; end
			3'd3: begin k_gain = stiff_lo_q[63:48]; d_gain = damp_lo_q[63:48]; end
			3'd4: begin k_gain = stiff_hi_q[15:0];  d_gain = damp_hi_q[15:0];  end
			3'd5: begin k_gain = stiff_hi_q[31:16]; d_gain = damp_hi_q[31:16]; end
			3'd6: begin k_gain = stiff_hi_q[47:32]; d_gain = damp_hi_q[47:32]; end
			default: begin k_gain = '0; d_gain = '0; end
		endcase
	end

	assign w_sat  = (smooth_q > ONE_Q16) ? ONE_Q16 : smooth_q;
	assign fv_old = fv_q[j_q];
	assign ft_old = ft_q[j_q];

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			ST_FV_HIST: begin op_a = 34'(fv_old); op_b = {1'b0, BETA_Q16};  end
			ST_FV_MEAS: begin op_a = 34'(vel_q);  op_b = {1'b0, ALPHA_Q16}; end
			ST_FT_HIST: begin op_a = 34'(ft_old); op_b = {1'b0, ONE_Q16 - w_sat}; end
			ST_FT_TGT:  begin op_a = 34'(tgt_q);  op_b = {1'b0, w_sat}; end
			ST_COR:     begin op_a = 34'(cor_q);  op_b = {2'b00, cor_scale_q}; end
			ST_STIFF: begin
				op_a = 34'(ft_new_q) - 34'(pos_q);
				op_b = {2'b00, k_gain};
			end
			ST_DAMP:    begin op_a = 34'(fv_new_q); op_b = {2'b00, d_gain}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// rounding of the registered product
	assign sum_round16 = acc_q + prod_q + 52'sd32768;
	assign r14         = (prod_q + 52'sd8192) >>> 14;
	assign r4          = (prod_q + 52'sd8) >>> 4;

	// accumulate the product of the previous step
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			case (step_q)
				ST_FV_MEAS: acc_q    <= prod_q;
				ST_FT_HIST: fv_new_q <= sum_round16[47:16];
				ST_FT_TGT:  acc_q    <= prod_q;
				ST_COR:     ft_new_q <= sum_round16[47:16];
				ST_STIFF:   tau_q    <= r14[47:0];
				ST_DAMP:    tau_q    <= tau_q + r4[47:0];
				ST_LAST:    tau_q    <= tau_q - r4[47:0];
				default: ;
			endcase
		end
		if (state_q == S_DIFF)
			diff_q <= 33'(tau_sat) - 33'(last_q);
	end

	// filter state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				fv_q[i] <= '0;
				ft_q[i] <= '0;
			end
		end else if (state_q == S_DIFF) begin
			fv_q[j_q] <= fv_new_q;
			ft_q[j_q] <= ft_new_q;
		end
	end

	// torque saturation
	always_comb begin
		if (tau_q > 48'sd2147483647)
			tau_sat = 32'sh7fffffff;
		else if (tau_q < -48'sd2147483648)
			tau_sat = 32'sh80000000;
		else
			tau_sat = tau_q[31:0];
	end

	// rate clamp and command saturation
	assign lim33 = {2'b00, limit_q};
	always_comb begin
		clamp_flag   = 1'b0;
		diff_clamped = diff_q;
		if (diff_q > lim33) begin
			diff_clamped = lim33;
			clamp_flag   = 1'b1;
		end else if (diff_q < -lim33) begin
			diff_clamped = -lim33;
			clamp_flag   = 1'b1;
		end
		cmd_wide = 34'(last_q) + 34'(diff_clamped);
		if (cmd_wide > 34'sd2147483647)
			cmd_sat = 32'sh7fffffff;
		else if (cmd_wide < -34'sd2147483648)
			cmd_sat = 32'sh80000000;
		else
			cmd_sat = cmd_wide[31:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			command.valid <= 1'b0;
		else if (out_load)
			command.valid <= 1'b1;
		else if (command.ready)
			command.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			command.joint_number   <= j_q;
			command.torque_command <= bypass_q ? last_q : cmd_sat;
			command.rate_limited   <= bypass_q ? 1'b0 : clamp_flag;
		end
	end

endmodule
